@@ sv/modular_arith_unit_assert.svh @@
// Assertion macros shared by the modular arithmetic unit modules.
`ifndef MODULAR_ARITH_UNIT_ASSERT_SVH
`define MODULAR_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define MAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define MAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mau_pkg.sv @@
// Shared types, constants and modular helpers for the modular arithmetic unit.
package mau_pkg;

	// datapath width and bit counter width
	localparam int MW    = 32;
	localparam int CNT_W = $clog2(MW);

	localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(MW - 1);
	localparam logic [MW-1:0]    RESET_MODULUS = MW'(1000000007);
	localparam logic [MW-1:0]    ONE           = MW'(1);
	localparam logic [MW-1:0]    TWO           = MW'(2);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_DISPATCH,
		ST_MUL,
		ST_POW_CHK,
		ST_POW_R,
		ST_POW_B,
		ST_FINAL,
		ST_DONE
	} state_t;

	// (a + b) mod m for a, b < m
	function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] a,
		input logic [MW-1:0] b, input logic [MW-1:0] m);
		logic [MW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[MW-1:0];
	endfunction

	// (a - b) mod m for a, b < m; wraps through m when a < b
	function automatic logic [MW-1:0] sub_mod(input logic [MW-1:0] a,
		input logic [MW-1:0] b, input logic [MW-1:0] m);
		logic [MW-1:0] d;
		d = a - b;
		if (a < b) begin
			d = d + m;
		end
		return d;
	endfunction

endpackage

@@ sv/modular_arith_unit.sv @@
// Modular arithmetic unit: add, subtract, multiply and Fermat-inverse divide mod a register.
// One request at a time. Operand reduction and each modular multiply run bit-serially.
// Add/subtract are computed in the dispatch state after reduction; multiply runs one modular multiply.
// Divide: divisor raised to modulus-2, a squaring per bit of modulus-2 and a multiply per set bit.
// A result waits in the output register while the next request is taken.
// arst_n clears the controller and output valid; modulus resets to 1000000007.
`include "modular_arith_unit_assert.svh"

module modular_arith_unit import mau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          modulus_we,
	input  logic [31:0]   modulus_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [63:0]   s_tdata,   // [31:0] left_operand, [63:32] right_operand
	input  logic [1:0]    s_tuser,   // [1:0] operation
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata    // [31:0] result
);

	state_t        state_q;
	state_t        state_d;
	logic [MW-1:0] mod_q;
	op_t           op_q;
	logic [MW-1:0] a_q;
	logic [MW-1:0] b_q;
	logic [MW-1:0] r_q;
	logic [MW-1:0] base_q;
	logic [MW-1:0] exp_q;
	logic [MW-1:0] pend_q;
	logic [MW-1:0] res_q;
	logic          out_valid_q;

	logic          in_acc;
	logic          mod_small;
	logic          red_start;
	logic          red_done_a;
	logic          red_done_b;
	logic [MW-1:0] red_a;
	logic [MW-1:0] red_b;
	logic          mul_start;
	logic [MW-1:0] mul_x;
	logic [MW-1:0] mul_y;
	logic          mul_done;
	logic [MW-1:0] mul_prod;
	logic          out_free;

	assign in_acc    = s_tvalid && s_tready;
	assign mod_small = (mod_q < TWO);
	assign out_free  = !out_valid_q || m_tready;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= RESET_MODULUS;
		end else if (modulus_we) begin
			mod_q <= modulus_wdata;
		end
	end

	mau_reduce u_red_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.value   (s_tdata[31:0]),
		.modulus (mod_q),
		.done    (red_done_a),
		.rem     (red_a)
	);

	mau_reduce u_red_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (red_start),
		.value   (s_tdata[63:32]),
		.modulus (mod_q),
		.done    (red_done_b),
		.rem     (red_b)
	);

	mau_mulmod u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.x       (mul_x),
		.y       (mul_y),
		.modulus (mod_q),
		.done    (mul_done),
		.prod    (mul_prod)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = mod_small ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (red_done_a) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (op_q)
					OP_ADD, OP_SUB: state_d = ST_DONE;
					OP_MUL:         state_d = ST_MUL;
					OP_DIV:         state_d = (b_q == '0) ? ST_DONE : ST_POW_CHK;
					default:        state_d = ST_DONE;
				endcase
			end
			ST_POW_CHK: begin
				priority if (exp_q == '0) begin
					state_d = ST_FINAL;
				end else if (exp_q[0]) begin
					state_d = ST_POW_R;
				end else begin
					state_d = ST_POW_B;
				end
			end
			ST_POW_R: begin
				if (mul_done) begin
					state_d = ST_POW_B;
				end
			end
			ST_POW_B: begin
				if (mul_done) begin
					state_d = ST_POW_CHK;
				end
			end
			ST_MUL, ST_FINAL: begin
				if (mul_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs: handshake, unit starts and multiplier operand select
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		red_start = 1'b0;
		mul_start = 1'b0;
		mul_x     = base_q;
		mul_y     = base_q;
		unique case (state_q)
			ST_IDLE: begin
				red_start = in_acc && !mod_small;
			end
			ST_DISPATCH: begin
				mul_start = (op_q == OP_MUL);
				mul_x     = a_q;
				mul_y     = b_q;
			end
			ST_POW_CHK: begin
				mul_start = 1'b1;
				priority if (exp_q == '0) begin
					mul_x = a_q;
					mul_y = r_q;
				end else if (exp_q[0]) begin
					mul_x = r_q;
					mul_y = base_q;
				end else begin
					mul_x = base_q;
					mul_y = base_q;
				end
			end
			ST_POW_R: begin
				mul_start = mul_done;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q   <= op_t'(s_tuser);
					pend_q <= '0;
				end
			end
			ST_REDUCE: begin
				if (red_done_a) begin
					a_q <= red_a;
					b_q <= red_b;
				end
			end
			ST_DISPATCH: begin
				unique case (op_q)
					OP_ADD:  pend_q <= add_mod(a_q, b_q, mod_q);
					OP_SUB:  pend_q <= sub_mod(a_q, b_q, mod_q);
					OP_DIV: begin
						pend_q <= '0;
						r_q    <= ONE;
						base_q <= b_q;
						exp_q  <= mod_q - TWO;
					end
					default: pend_q <= '0;
				endcase
			end
			ST_POW_R: begin
				if (mul_done) begin
					r_q <= mul_prod;
				end
			end
			ST_POW_B: begin
				if (mul_done) begin
					base_q <= mul_prod;
					exp_q  <= {1'b0, exp_q[MW-1:1]};
				end
			end
			ST_MUL, ST_FINAL: begin
				if (mul_done) begin
					pend_q <= mul_prod;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_q <= pend_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	`MAU_ASSERT_NOW(a_red_in_step, 1'b1, red_done_a == red_done_b, "operand reducers out of step")
	`MAU_ASSERT_NOW(a_pend_bound, state_q == ST_DONE, pend_q == '0 || pend_q < mod_q, "result not below modulus")
	`MAU_ASSERT_NOW(a_pow_bound, state_q == ST_POW_CHK, a_q < mod_q && r_q < mod_q && base_q < mod_q, "exponentiation operand out of range")
	`MAU_ASSERT_NEXT(a_load_valid, state_q == ST_DONE && out_free, m_tvalid, "result not presented after completion")

endmodule

@@ sv/mau_reduce.sv @@
// Bit-serial remainder unit: value mod modulus, one dividend bit per cycle.
`include "modular_arith_unit_assert.svh"

module mau_reduce import mau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] value,
	input  logic [MW-1:0] modulus,
	output logic          done,
	output logic [MW-1:0] rem
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW-1:0]    val_q;
	logic [MW-1:0]    rem_q;
	logic [MW:0]      trial;
	logic [MW:0]      trial_sub;

	// shift in next dividend bit, subtract modulus once if it fits
	assign trial     = {rem_q, val_q[MW-1]};
	assign trial_sub = (trial >= {1'b0, modulus}) ? (trial - {1'b0, modulus}) : trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[MW-2:0], 1'b0};
			rem_q <= trial_sub[MW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`MAU_ASSERT_NOW(a_red_no_restart, start, !busy_q, "reducer restarted while busy")
	`MAU_ASSERT_NOW(a_red_rem_bound, busy_q && modulus >= TWO, rem_q < modulus, "remainder out of range")
	`MAU_ASSERT_NEXT(a_red_done_pulse, done_q, !done_q, "reducer done held for two cycles")

endmodule

@@ sv/mau_mulmod.sv @@
// Bit-serial modular multiplier: shift-and-add over the multiplier bits, LSB first.
`include "modular_arith_unit_assert.svh"

module mau_mulmod import mau_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] x,
	input  logic [MW-1:0] y,
	input  logic [MW-1:0] modulus,
	output logic          done,
	output logic [MW-1:0] prod
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW-1:0]    acc_q;
	logic [MW-1:0]    a_q;
	logic [MW-1:0]    b_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_LAST;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate a when the multiplier bit is set, double a every step
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= x;
			b_q   <= y;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= add_mod(acc_q, a_q, modulus);
			end
			a_q <= add_mod(a_q, a_q, modulus);
			b_q <= {1'b0, b_q[MW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	`MAU_ASSERT_NOW(a_mul_no_restart, start, !busy_q, "multiplier restarted while busy")
	`MAU_ASSERT_NOW(a_mul_op_bound, start, x < modulus && y < modulus, "multiplier operand not reduced")
	`MAU_ASSERT_NOW(a_mul_acc_bound, busy_q, acc_q < modulus && a_q < modulus, "accumulator out of range")

endmodule
